[rtl/qpss_pkg.sv]
// Package: shared constants and types for the scanline sweep core.
package qpss_pkg;
  localparam int MaxSegments = 16;
  localparam int CoordBits = 32;
  localparam int ResultLimit = 32;
  localparam int MaskBits = 16;
  localparam int ResultCntBits = 6;

  typedef struct packed {
    logic start;
    logic update;
    logic clear;
  } qpss_ctl_t;
endpackage

[rtl/qpss_if.sv]
// Interfaces: valid/ready channels for input points and result bands.
interface qpss_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic last_point;
  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface qpss_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] band_low;
  logic signed [31:0] band_high;
  logic [15:0] active_mask;
  logic any_active;
  logic last_band;
  logic overflow;
  modport source(output valid, band_low, band_high, active_mask, any_active, last_band,
    overflow, input ready);
  modport sink(input valid, band_low, band_high, active_mask, any_active, last_band,
    overflow, output ready);
endinterface

[rtl/qpss_cell.sv]
// Cell: one stored segment span; compares it with the sweep y and passes the running next y.
module qpss_cell #(
  parameter int COORD_BITS = qpss_pkg::CoordBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic signed [COORD_BITS-1:0] wr_lo,
  input  logic signed [COORD_BITS-1:0] wr_hi,
  input  qpss_pkg::qpss_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic                         in_more,
  input  logic signed [COORD_BITS-1:0] in_next,
  output logic                         out_more,
  output logic signed [COORD_BITS-1:0] out_next,
  output logic                         act
);
  import qpss_pkg::*;
  logic signed [COORD_BITS-1:0] lo_r, hi_r;
  logic used_r, act_r;
  logic m1;
  logic signed [COORD_BITS-1:0] n1;
  logic more_r;
  logic signed [COORD_BITS-1:0] next_r;

  always_comb begin
    m1 = in_more;
    n1 = in_next;
    if (used_r && ctl.start) begin
      if (!m1 || lo_r < n1) begin
        m1 = 1'b1;
        n1 = lo_r;
      end
    end else if (used_r) begin
      if (lo_r > cur_y && (!m1 || lo_r < n1)) begin
        m1 = 1'b1;
        n1 = lo_r;
      end
      if (hi_r > cur_y && (!m1 || hi_r < n1)) begin
        m1 = 1'b1;
        n1 = hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_r <= wr_lo;
      hi_r <= wr_hi;
    end
    next_r <= n1;
    if (!rst_n) begin
      more_r <= 1'b0;
    end else begin
      more_r <= m1;
    end
    if (!rst_n || ctl.clear) begin
      used_r <= 1'b0;
      act_r <= 1'b0;
    end else begin
      if (wr_en) used_r <= 1'b1;
      if (ctl.update && used_r) act_r <= (act_r || lo_r == cur_y) && !(hi_r == cur_y);
    end
  end

  assign out_more = more_r;
  assign out_next = next_r;
  assign act = act_r;
endmodule

[rtl/quadratic_path_scanline_sweep_core.sv]
// Top level: point loader, row of span cells and band sweep sequencer.
// Sequence: points are taken one per cycle while loading (S_LOAD); after the last
// point a close state (S_CLOSE), then S_FIRST sweeps the cell row for the lowest span end;
// each band then takes a scan of the cells (S_SCAN) and an emit state (S_EMIT), held until
// the result is taken. The next band is not scanned before the current one is taken.
// Reset (rst_n low, synchronous) clears path state, band_top and the cell valid bits.
module quadratic_path_scanline_sweep_core #(
  parameter int MAX_SEGMENTS = qpss_pkg::MaxSegments,
  parameter int COORD_BITS = qpss_pkg::CoordBits
) (
  input logic clk,
  input logic rst_n,
  qpss_in_if.sink   in_ch,
  qpss_out_if.source out_ch
);
  import qpss_pkg::*;
  localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
  localparam int IdxBits = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MB = (MAX_SEGMENTS < MaskBits) ? MAX_SEGMENTS : MaskBits;

  typedef enum logic [2:0] {S_LOAD, S_CLOSE, S_FIRST, S_SCAN, S_EMIT} state_t;
  state_t state_r;

  logic signed [COORD_BITS-1:0] x, y;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, ex_r, ey_r, slo_r, shi_r, lo_n, hi_n;
  logic signed [COORD_BITS-1:0] cur_r, next_r, top_r;
  logic started_r, have_r, odd_r, ovf_r;
  logic [CntBits-1:0] cnt_r;
  logic [CntBits-1:0] scan_r;
  logic scan_done;
  logic [ResultCntBits-1:0] nres_r;
  logic wr_en;
  logic signed [COORD_BITS-1:0] wr_lo, wr_hi;
  qpss_ctl_t ctl;
  logic [MAX_SEGMENTS:0] mch;
  logic signed [COORD_BITS-1:0] nch [MAX_SEGMENTS+1];
  logic [MAX_SEGMENTS-1:0] act;
  logic ov_r, last_r;
  logic signed [31:0] blo_r, bhi_r;
  logic acc, seg_add;

  assign x = in_ch.point_x[COORD_BITS-1:0];
  assign y = in_ch.point_y[COORD_BITS-1:0];
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_LOAD);
  assign lo_n = (y < slo_r) ? y : slo_r;
  assign hi_n = (y > shi_r) ? y : shi_r;
  assign seg_add = acc && started_r && !odd_r;
  assign scan_done = (scan_r == CntBits'(MAX_SEGMENTS));

  always_comb begin
    wr_en = 1'b0;
    wr_lo = lo_n;
    wr_hi = hi_n;
    if (seg_add && cnt_r < CntBits'(MAX_SEGMENTS)) wr_en = 1'b1;
    if (state_r == S_CLOSE) begin
      wr_lo = (ey_r < fy_r) ? ey_r : fy_r;
      wr_hi = (ey_r < fy_r) ? fy_r : ey_r;
      wr_en = have_r && (ex_r != fx_r || ey_r != fy_r) && cnt_r < CntBits'(MAX_SEGMENTS);
    end
    ctl.start = (state_r == S_FIRST);
    ctl.update = (state_r == S_SCAN) && scan_done;
    ctl.clear = (state_r == S_EMIT) && out_ch.ready && last_r;
  end

  assign mch[0] = 1'b0;
  assign nch[0] = '0;
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    qpss_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .wr_en(wr_en && cnt_r[IdxBits-1:0] == IdxBits'(i) && (cnt_r < CntBits'(MAX_SEGMENTS))),
      .wr_lo(wr_lo), .wr_hi(wr_hi), .ctl(ctl), .cur_y(cur_r),
      .in_more(mch[i]), .in_next(nch[i]), .out_more(mch[i+1]), .out_next(nch[i+1]),
      .act(act[i]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      started_r <= 1'b0; have_r <= 1'b0; odd_r <= 1'b0; ovf_r <= 1'b0;
      cnt_r <= '0; nres_r <= '0; top_r <= '0; scan_r <= '0;
      fx_r <= '0; fy_r <= '0; ex_r <= '0; ey_r <= '0; slo_r <= '0; shi_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: if (acc) begin
          if (!started_r) begin
            fx_r <= x; fy_r <= y; slo_r <= y; shi_r <= y; started_r <= 1'b1; odd_r <= 1'b1;
          end else if (odd_r) begin
            slo_r <= lo_n; shi_r <= hi_n; odd_r <= 1'b0;
          end else begin
            if (cnt_r < CntBits'(MAX_SEGMENTS)) cnt_r <= cnt_r + 1'b1;
            else ovf_r <= 1'b1;
            ex_r <= x; ey_r <= y; have_r <= 1'b1; slo_r <= y; shi_r <= y; odd_r <= 1'b1;
          end
          if (in_ch.last_point) state_r <= S_CLOSE;
        end
        S_CLOSE: begin
          if (have_r && (ex_r != fx_r || ey_r != fy_r)) begin
            if (cnt_r < CntBits'(MAX_SEGMENTS)) cnt_r <= cnt_r + 1'b1;
            else ovf_r <= 1'b1;
          end
          nres_r <= '0;
          scan_r <= '0;
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          if (cnt_r == '0) begin
            blo_r <= 32'(top_r); bhi_r <= 32'(top_r);
            last_r <= 1'b1; ov_r <= ovf_r; state_r <= S_EMIT;
          end else if (scan_done) begin
            cur_r <= nch[MAX_SEGMENTS];
            scan_r <= '0;
            state_r <= S_SCAN;
          end else scan_r <= scan_r + 1'b1;
        end
        S_SCAN: begin
          if (scan_done) begin
            next_r <= nch[MAX_SEGMENTS];
            if (mch[MAX_SEGMENTS]) top_r <= nch[MAX_SEGMENTS];
            last_r <= !mch[MAX_SEGMENTS] ||
              (nres_r + 1'b1 >= ResultCntBits'(ResultLimit));
            blo_r <= 32'(cur_r);
            bhi_r <= mch[MAX_SEGMENTS] ? 32'(nch[MAX_SEGMENTS]) : 32'(top_r);
            ov_r <= ovf_r;
            state_r <= S_EMIT;
          end else scan_r <= scan_r + 1'b1;
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            nres_r <= nres_r + 1'b1;
            if (last_r) begin
              state_r <= S_LOAD;
              started_r <= 1'b0; have_r <= 1'b0; odd_r <= 1'b0; ovf_r <= 1'b0;
              cnt_r <= '0;
            end else begin
              cur_r <= next_r;
              scan_r <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  logic [MAX_SEGMENTS-1:0] act_now;
  always_comb begin
    act_now = act;
  end

  assign out_ch.valid = (state_r == S_EMIT);
  assign out_ch.band_low = blo_r;
  assign out_ch.band_high = bhi_r;
  assign out_ch.active_mask = (cnt_r == '0) ? 16'h0 : 16'(act_now[MB-1:0]);
  assign out_ch.any_active = (cnt_r != '0) && (|act_now);
  assign out_ch.last_band = last_r;
  assign out_ch.overflow = ov_r;
endmodule

[rtl/qpss_checker.sv]
// Checker: port-level assertions for the sweep core, bound to the top level.
module qpss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_band,
  input logic out_any_active,
  input logic [15:0] out_active_mask
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during sweep");
  a_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_active_mask != 16'h0 |-> out_any_active) else $error("any_active low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_band |=> !out_valid) else $error("band after last");
endmodule

bind quadratic_path_scanline_sweep_core qpss_checker u_qpss_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last_band(out_ch.last_band),
  .out_any_active(out_ch.any_active), .out_active_mask(out_ch.active_mask));
